// ===== rtl/tlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants for the three-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

    // sizing
    localparam int LEVEL_DEPTH = 16;
    localparam int TICKET_BITS = 16;
    localparam int NUM_LEVELS  = 3;

    localparam int PTR_W    = $clog2(LEVEL_DEPTH);
    localparam int CNT_W    = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W   = $clog2(NUM_LEVELS * LEVEL_DEPTH);
    localparam int STORE_N  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int TICKET_W = 16;
    localparam int AGE_W    = 7;
    localparam int SEV_W    = 2;

    // severity codes
    localparam logic [SEV_W-1:0] SEV_REGULAR = 2'd0;
    localparam logic [SEV_W-1:0] SEV_BAD     = 2'd1;
    localparam logic [SEV_W-1:0] SEV_WORST   = 2'd2;

    // request modes
    localparam logic MODE_ADMIT = 1'b0;
    localparam logic MODE_SERVE = 1'b1;

    typedef enum logic [1:0] {
        ST_ADMITTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [AGE_W-1:0]  age;
        logic [SEV_W-1:0]  severity;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [TICKET_W-1:0]  ticket;
        logic [AGE_W-1:0]     served_age;
        logic [SEV_W-1:0]     served_severity;
    } t_rsp;

    // one stored entry
    typedef struct packed {
        logic [TICKET_W-1:0]  ticket;
        logic [AGE_W-1:0]     age;
    } t_entry;

endpackage

// ===== rtl/tlpq_store.sv =====
// ----------------------------------------------------------------------------
// tlpq_store
// Entry storage for all three levels, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlpq_store (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [tlpq_pkg::ADDR_W-1:0]  i_wr_addr,
    input  tlpq_pkg::t_entry             i_wr_data,
    input  logic                         i_rd_en,
    input  logic [tlpq_pkg::ADDR_W-1:0]  i_rd_addr,
    output tlpq_pkg::t_entry             o_rd_data
);

    tlpq_pkg::t_entry r_mem [tlpq_pkg::STORE_N];
    tlpq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/three_level_priority_queue.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Strict priority queue over three severity levels, each a FIFO of
// {ticket, age} entries; admit appends with a fresh ticket, serve pops the
// oldest entry of the most severe non-empty level.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+-------------------------------
//  request   | in        | start / busy      | i_req  (mode, age, severity)
//  result    | out       | o_done strobe     | o_rsp  (status, ticket,
//            |           |                   |         served_age,
//            |           |                   |         served_severity)
//
//  busy is held low: one item is taken on every cycle that start is high
//  every item gives one result, strobed via r_req_vld, r_meta_vld and r_done
//  stage 1 registers the item, stage 2 updates pointers, counts and storage
//  and reads the entry store, stage 3 registers the result
//  synchronous active-low reset clears pointers, counts and valid flags and
//  sets the next ticket to one; entry storage is not cleared
//  results cannot be held off, so nothing ever stalls
//
module three_level_priority_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tlpq_pkg::t_req  i_req,
    output logic            o_done,
    output tlpq_pkg::t_rsp  o_rsp
);

    localparam int PTR_W  = tlpq_pkg::PTR_W;
    localparam int CNT_W  = tlpq_pkg::CNT_W;
    localparam int ADDR_W = tlpq_pkg::ADDR_W;
    localparam int NLVL   = tlpq_pkg::NUM_LEVELS;

    // stage 2 to stage 3 bookkeeping
    typedef struct packed {
        logic                           served;
        tlpq_pkg::t_status              status;
        logic [tlpq_pkg::TICKET_W-1:0]  ticket;
        logic [tlpq_pkg::SEV_W-1:0]     sev;
    } t_meta;

    // wrap a level pointer
    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(tlpq_pkg::LEVEL_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // flat store address of a level slot
    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [tlpq_pkg::SEV_W-1:0] lvl,
        input logic [PTR_W-1:0]           ptr
    );
        return ADDR_W'(lvl) * ADDR_W'(tlpq_pkg::LEVEL_DEPTH) + ADDR_W'(ptr);
    endfunction

    // stage 1: input register
    logic              r_req_vld;
    tlpq_pkg::t_req    r_req;

    // queue state
    logic [PTR_W-1:0]                 r_head  [NLVL];
    logic [PTR_W-1:0]                 r_tail  [NLVL];
    logic [CNT_W-1:0]                 r_count [NLVL];
    logic [tlpq_pkg::TICKET_BITS-1:0] r_next_ticket;

    logic [PTR_W-1:0]                 n_head  [NLVL];
    logic [PTR_W-1:0]                 n_tail  [NLVL];
    logic [CNT_W-1:0]                 n_count [NLVL];
    logic [tlpq_pkg::TICKET_BITS-1:0] n_next_ticket;

    // stage 2 outputs
    logic    r_meta_vld;
    t_meta   r_meta;
    t_meta   n_meta;

    // stage 3: result register
    logic            r_done;
    tlpq_pkg::t_rsp  r_rsp;
    tlpq_pkg::t_rsp  n_rsp;

    // stage 2 decode
    logic [tlpq_pkg::SEV_W-1:0] sev_sat;
    logic [tlpq_pkg::SEV_W-1:0] pick_lvl;
    logic                       any_waiting;
    logic                       lvl_full;
    logic                       do_admit;
    logic                       do_serve;

    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    tlpq_pkg::t_entry           wr_data;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    tlpq_pkg::t_entry           rd_data;

    assign busy = 1'b0;

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb begin
        // code 3 counts as worst
        sev_sat  = (r_req.severity > tlpq_pkg::SEV_WORST) ? tlpq_pkg::SEV_WORST
                                                          : r_req.severity;
        lvl_full = (r_count[sev_sat] == CNT_W'(tlpq_pkg::LEVEL_DEPTH));

        // strict priority: worst, then bad, then regular
        any_waiting = 1'b1;
        if (r_count[tlpq_pkg::SEV_WORST] != '0) begin
            pick_lvl = tlpq_pkg::SEV_WORST;
        end else if (r_count[tlpq_pkg::SEV_BAD] != '0) begin
            pick_lvl = tlpq_pkg::SEV_BAD;
        end else begin
            pick_lvl    = tlpq_pkg::SEV_REGULAR;
            any_waiting = (r_count[tlpq_pkg::SEV_REGULAR] != '0);
        end

        do_admit = r_req_vld && (r_req.mode == tlpq_pkg::MODE_ADMIT) && !lvl_full;
        do_serve = r_req_vld && (r_req.mode == tlpq_pkg::MODE_SERVE) && any_waiting;

        wr_en          = do_admit;
        wr_addr        = slot_addr(sev_sat, r_tail[sev_sat]);
        wr_data.ticket = tlpq_pkg::TICKET_W'(r_next_ticket);
        wr_data.age    = r_req.age;
        rd_en          = do_serve;
        rd_addr        = slot_addr(pick_lvl, r_head[pick_lvl]);

        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_next_ticket = r_next_ticket;
        if (do_admit) begin
            n_tail[sev_sat]  = bump(r_tail[sev_sat]);
            n_count[sev_sat] = r_count[sev_sat] + 1'b1;
            n_next_ticket    = r_next_ticket + 1'b1;
        end
        if (do_serve) begin
            n_head[pick_lvl]  = bump(r_head[pick_lvl]);
            n_count[pick_lvl] = r_count[pick_lvl] - 1'b1;
        end

        // result bookkeeping; served ticket and age come from the store
        n_meta.served = 1'b0;
        n_meta.ticket = '0;
        n_meta.sev    = '0;
        if (r_req.mode == tlpq_pkg::MODE_ADMIT) begin
            n_meta.sev = sev_sat;
            if (lvl_full) begin
                n_meta.status = tlpq_pkg::ST_FULL;
            end else begin
                n_meta.status = tlpq_pkg::ST_ADMITTED;
                n_meta.ticket = tlpq_pkg::TICKET_W'(r_next_ticket);
            end
        end else if (any_waiting) begin
            n_meta.status = tlpq_pkg::ST_SERVED;
            n_meta.served = 1'b1;
            n_meta.sev    = pick_lvl;
        end else begin
            n_meta.status = tlpq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NLVL; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
            r_next_ticket <= tlpq_pkg::TICKET_BITS'(1);
            r_meta_vld    <= 1'b0;
        end else begin
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_next_ticket <= n_next_ticket;
            r_meta_vld    <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_meta <= n_meta;
        end
    end

    // entry storage, read data lands together with r_meta
    tlpq_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------- stage 3
    always_comb begin
        n_rsp.status          = r_meta.status;
        n_rsp.served_severity = r_meta.sev;
        if (r_meta.served) begin
            n_rsp.ticket     = rd_data.ticket;
            n_rsp.served_age = rd_data.age;
        end else begin
            n_rsp.ticket     = r_meta.ticket;
            n_rsp.served_age = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_meta_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_meta_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== tb/tlpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_checker
// Watches the request and result channels of the three-level priority queue,
// keeps its own copy of the three level FIFOs and the ticket counter, and
// compares every strobed result with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module tlpq_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  tlpq_pkg::t_req  i_req,
    input  logic            i_done,
    input  tlpq_pkg::t_rsp  i_rsp,
    input  logic            i_drain,
    output int              o_fail_count,
    output int              o_pending
);

    localparam int NUM_LEVELS  = tlpq_pkg::NUM_LEVELS;
    localparam int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH;
    localparam int PTR_W       = tlpq_pkg::PTR_W;
    localparam int CNT_W       = tlpq_pkg::CNT_W;
    localparam int TICKET_W    = tlpq_pkg::TICKET_W;
    localparam int SEV_W       = tlpq_pkg::SEV_W;

    // mirror of the queue state
    tlpq_pkg::t_entry     level_store [NUM_LEVELS][LEVEL_DEPTH];
    logic [PTR_W-1:0]     level_head  [NUM_LEVELS];
    logic [PTR_W-1:0]     level_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]     level_count [NUM_LEVELS];
    logic [TICKET_W-1:0]  next_ticket;

    tlpq_pkg::t_rsp expected_outcomes [$];
    int   fail_count = 0;
    bit   drain_reported = 1'b0;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("%0t ns mismatch, %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic predict_outcome(input tlpq_pkg::t_req req, output tlpq_pkg::t_rsp rsp);
        logic [SEV_W-1:0] sev;
        logic [PTR_W-1:0] p;
        int               lvl;
        rsp = '0;
        if (req.mode == tlpq_pkg::MODE_ADMIT) begin
            // severity code 3 counts as worst
            sev = (req.severity > tlpq_pkg::SEV_WORST) ? tlpq_pkg::SEV_WORST
                                                       : req.severity;
            rsp.served_severity = sev;
            if (level_count[sev] >= LEVEL_DEPTH) begin
                rsp.status = tlpq_pkg::ST_FULL;
            end else begin
                p = level_tail[sev];
                level_store[sev][p].ticket = next_ticket;
                level_store[sev][p].age    = req.age;
                level_tail[sev]  = bump(p);
                level_count[sev] = level_count[sev] + 1'b1;
                rsp.status = tlpq_pkg::ST_ADMITTED;
                rsp.ticket = next_ticket;
                next_ticket = next_ticket + 1'b1;
            end
        end else begin
            lvl = -1;
            for (int k = NUM_LEVELS - 1; k >= 0; k--)
                if (lvl < 0 && level_count[k] != 0)
                    lvl = k;
            if (lvl < 0) begin
                rsp.status = tlpq_pkg::ST_EMPTY;
            end else begin
                p = level_head[lvl];
                rsp.status          = tlpq_pkg::ST_SERVED;
                rsp.ticket          = level_store[lvl][p].ticket;
                rsp.served_age      = level_store[lvl][p].age;
                rsp.served_severity = lvl[SEV_W-1:0];
                level_head[lvl]  = bump(p);
                level_count[lvl] = level_count[lvl] - 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        tlpq_pkg::t_rsp want;
        tlpq_pkg::t_rsp outcome;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                level_head[k]  = '0;
                level_tail[k]  = '0;
                level_count[k] = '0;
            end
            next_ticket = TICKET_W'(1);
            expected_outcomes.delete();
        end else begin
            // results first: an item accepted at this edge cannot be strobed yet
            if (i_done) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result with nothing outstanding, ticket",
                                    i_rsp.ticket, -1);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", i_rsp.status, want.status);
                    if (i_rsp.ticket !== want.ticket)
                        report_mismatch("ticket", i_rsp.ticket, want.ticket);
                    if (i_rsp.served_age !== want.served_age)
                        report_mismatch("served_age", i_rsp.served_age, want.served_age);
                    if (i_rsp.served_severity !== want.served_severity)
                        report_mismatch("served_severity", i_rsp.served_severity,
                                        want.served_severity);
                end
            end
            if (i_start && !i_busy) begin
                predict_outcome(i_req, outcome);
                expected_outcomes.push_back(outcome);
            end
            if (i_drain && !drain_reported) begin
                drain_reported = 1'b1;
                if (expected_outcomes.size() != 0)
                    report_mismatch("results never delivered", 0,
                                    expected_outcomes.size());
            end
        end
        o_pending    <= expected_outcomes.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/three_level_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_priority_queue_tb
// Drives admit and serve items into the three-level priority queue and lets
// the checker predict and compare every result: a short directed opening,
// then random bursts under three idling regimes.
// ----------------------------------------------------------------------------
module three_level_priority_queue_tb;

    localparam int ITEMS_PER_PHASE = 450;   // three phases, about 1350 items
    localparam int STALL_LIMIT     = 5000;  // cycles with no item and no result
    localparam int AGE_W           = tlpq_pkg::AGE_W;
    localparam int SEV_W           = tlpq_pkg::SEV_W;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    tlpq_pkg::t_req i_req;
    logic o_done;
    tlpq_pkg::t_rsp o_rsp;
    logic drain;

    int fail_count;
    int pending;
    int stall_cycles = 0;

    three_level_priority_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    tlpq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_drain      (drain),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: a run that stops moving is a failure
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one item: random idle cycles first, then start held until accepted
    task automatic send_item(input tlpq_pkg::t_req req, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= tlpq_pkg::t_req'($urandom);     // junk while idle
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_fields(input logic mode, input logic [AGE_W-1:0] age,
                               input logic [SEV_W-1:0] sev, input int idle_pct);
        tlpq_pkg::t_req req;
        req.mode     = mode;
        req.age      = age;
        req.severity = sev;
        send_item(req, idle_pct);
    endtask

    // random part: bursts deep enough to fill and empty levels, plus noise
    task automatic run_random(input int n_items, input int idle_pct);
        int sent;
        int len;
        int pick;
        logic [SEV_W-1:0] sev;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(9);
            len  = $urandom_range(1, 20);
            sev  = SEV_W'($urandom_range(3));
            for (int k = 0; k < len; k++) begin
                case (pick)
                    0, 1, 2, 3: begin
                        // admit burst into one level, up to 20 long, so it can hit full
                        send_fields(tlpq_pkg::MODE_ADMIT, AGE_W'($urandom), sev,
                                    idle_pct);
                    end
                    4, 5, 6: begin
                        // serve burst with junk in the ignored fields
                        send_fields(tlpq_pkg::MODE_SERVE, AGE_W'($urandom),
                                    SEV_W'($urandom), idle_pct);
                    end
                    7, 8: begin
                        send_fields(1'($urandom), AGE_W'($urandom), SEV_W'($urandom),
                                    idle_pct);
                    end
                    default: begin
                        send_item(tlpq_pkg::t_req'($urandom), idle_pct);
                    end
                endcase
            end
            sent += len;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        drain   <= 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        send_fields(tlpq_pkg::MODE_SERVE, '0, '0, 0);        // serve with all levels empty
        send_fields(tlpq_pkg::MODE_SERVE, '1, '1, 0);        // ignored fields all ones
        send_fields(tlpq_pkg::MODE_ADMIT, '0, tlpq_pkg::SEV_REGULAR, 0); // youngest age
        send_fields(tlpq_pkg::MODE_ADMIT, '1, tlpq_pkg::SEV_BAD, 0);     // oldest age
        send_fields(tlpq_pkg::MODE_ADMIT, 7'h55, tlpq_pkg::SEV_WORST, 0);
        send_fields(tlpq_pkg::MODE_ADMIT, 7'h2a, 2'd3, 0);   // code 3 saturates to worst
        send_fields(tlpq_pkg::MODE_ADMIT, 7'h11, tlpq_pkg::SEV_REGULAR, 0);
        send_fields(tlpq_pkg::MODE_SERVE, '0, '0, 0);        // worst, oldest first
        send_fields(tlpq_pkg::MODE_SERVE, '0, '0, 0);
        send_fields(tlpq_pkg::MODE_SERVE, '0, '0, 0);        // then bad
        send_fields(tlpq_pkg::MODE_SERVE, '0, '0, 0);        // then regular, in order
        send_fields(tlpq_pkg::MODE_SERVE, '0, '0, 0);
        send_fields(tlpq_pkg::MODE_SERVE, '0, '0, 0);        // empty again
        send_fields(tlpq_pkg::MODE_ADMIT, 7'h40, tlpq_pkg::SEV_BAD, 0);
        send_fields(tlpq_pkg::MODE_ADMIT, 7'h01, tlpq_pkg::SEV_REGULAR, 0);
        send_fields(tlpq_pkg::MODE_ADMIT, 7'h7e, tlpq_pkg::SEV_WORST, 0);
        send_fields(tlpq_pkg::MODE_SERVE, '1, '1, 0);

        // random bursts under three idling regimes
        run_random(ITEMS_PER_PHASE, 34);
        run_random(ITEMS_PER_PHASE, 51);
        run_random(ITEMS_PER_PHASE, 0);

        @(negedge i_clk);
        start <= 1'b0;

        // drain: watchdog bounds this wait
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        drain <= 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
